/* rtl/text_console_writer_macros.svh */
// Assertion macros for the console writer RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
// Console writer package: geometry, cell codes, opcodes and shared types.
// No dependencies.
package tcw_pkg;

  localparam int NUM_COLUMNS = 80;
  localparam int NUM_ROWS    = 25;
  localparam int NUM_CELLS   = NUM_ROWS * NUM_COLUMNS;

  localparam int COL_W     = $clog2(NUM_COLUMNS);
  localparam int ROW_W     = (NUM_ROWS > 2) ? $clog2(NUM_ROWS) : 1;
  localparam int ROW_SUM_W = ROW_W + 1;
  localparam int ADDR_W    = $clog2(NUM_CELLS);
  localparam int CELL_W    = 16;

  localparam int TAB_MASK = 7;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_MOVE = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } ram_req_t;

endpackage

/* rtl/tcw_cmd_if.sv */
// Command channel of the console writer: valid/ready plus one command.
// Depends on tcw_pkg.
interface tcw_cmd_if;
  logic          valid;
  logic          ready;
  tcw_pkg::op_t  op;
  logic [7:0]    char_code;
  logic [6:0]    col;
  logic [4:0]    row;

  modport source (output valid, output op, output char_code, output col, output row,
                  input ready);
  modport sink (input valid, input op, input char_code, input col, input row,
                output ready);
endinterface

/* rtl/tcw_rsp_if.sv */
// Response channel of the console writer: valid/ready plus one result.
// No dependencies.
interface tcw_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic       scrolled;
  logic       rejected;

  modport source (output valid, output cursor_col, output cursor_row, output cell_char,
                  output cell_attr, output scrolled, output rejected, input ready);
  modport sink (input valid, input cursor_col, input cursor_row, input cell_char,
                input cell_attr, input scrolled, input rejected, output ready);
endinterface

/* rtl/tcw_cell_ram.sv */
// Single-port synchronous RAM with registered read data.
// No dependencies.
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/tcw_ctrl.sv */
// Console sequencer: cursor, scroll offset, clearing pass and cell RAM access.
// Depends on tcw_pkg, tcw_cmd_if and text_console_writer_macros.svh.
`include "text_console_writer_macros.svh"

module tcw_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    attr,
  tcw_cmd_if.sink                       cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tcw_pkg::res_t                 res,
  output tcw_pkg::ram_req_t             ram_req,
  input  logic [tcw_pkg::CELL_W-1:0]    ram_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TAB,
    S_SCROLL,
    S_READ,
    S_DONE
  } state_t;

  state_t                          state;
  logic [tcw_pkg::ADDR_W-1:0]      clr_cnt;
  logic [tcw_pkg::ROW_W-1:0]       cur_row;
  logic [tcw_pkg::COL_W-1:0]       cur_col;
  logic [tcw_pkg::ROW_W-1:0]       top;
  logic [tcw_pkg::COL_W-1:0]       k;
  logic [tcw_pkg::COL_W-1:0]       tab_last;
  logic [tcw_pkg::COL_W-1:0]       tab_next;
  logic                            tab_wrap;
  logic                            scrolled;
  logic                            rejected;
  logic [7:0]                      cell_char;
  logic [7:0]                      cell_attr;

  logic                            cmd_fire;
  logic                            in_range;
  logic                            is_read;
  logic                            printable;
  logic                            last_row;
  logic                            last_col;
  logic [tcw_pkg::COL_W-1:0]       tab_mask_col;
  logic                            tab_wrap_c;
  logic [tcw_pkg::ROW_W-1:0]       lrow;
  logic [tcw_pkg::ROW_SUM_W-1:0]   row_sum;
  logic [tcw_pkg::ROW_W-1:0]       prow;
  logic [tcw_pkg::COL_W-1:0]       acol;
  logic [tcw_pkg::ADDR_W-1:0]      cell_addr;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign in_range  = (32'(cmd.col) < tcw_pkg::NUM_COLUMNS) &&
                     (32'(cmd.row) < tcw_pkg::NUM_ROWS);
  assign is_read   = (cmd.op == tcw_pkg::OP_READ);
  assign printable = (cmd.char_code != tcw_pkg::CH_NEWLINE) &&
                     (cmd.char_code != tcw_pkg::CH_RETURN) &&
                     (cmd.char_code != tcw_pkg::CH_TAB);
  assign last_row  = (cur_row == tcw_pkg::ROW_W'(tcw_pkg::NUM_ROWS - 1));
  assign last_col  = (cur_col == tcw_pkg::COL_W'(tcw_pkg::NUM_COLUMNS - 1));

  assign tab_mask_col = cur_col | tcw_pkg::COL_W'(tcw_pkg::TAB_MASK);
  assign tab_wrap_c   = (tab_mask_col >= tcw_pkg::COL_W'(tcw_pkg::NUM_COLUMNS - 1));

  // logical row to physical row through the ring offset
  assign lrow    = (state == S_IDLE && is_read) ? tcw_pkg::ROW_W'(cmd.row) : cur_row;
  assign row_sum = tcw_pkg::ROW_SUM_W'(top) + tcw_pkg::ROW_SUM_W'(lrow);

  always_comb begin
    if (state == S_SCROLL) begin
      prow = top;
    end else if (row_sum >= tcw_pkg::ROW_SUM_W'(tcw_pkg::NUM_ROWS)) begin
      prow = tcw_pkg::ROW_W'(row_sum - tcw_pkg::ROW_SUM_W'(tcw_pkg::NUM_ROWS));
    end else begin
      prow = tcw_pkg::ROW_W'(row_sum);
    end
    if (state == S_IDLE) begin
      acol = is_read ? tcw_pkg::COL_W'(cmd.col) : cur_col;
    end else begin
      acol = k;
    end
  end

  assign cell_addr = tcw_pkg::ADDR_W'(32'(prow) * tcw_pkg::NUM_COLUMNS + 32'(acol));

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = cell_addr;
    ram_req.wdata = {attr, tcw_pkg::BLANK_CHAR};
    unique case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_cnt;
        ram_req.wdata = tcw_pkg::RESET_CELL;
      end
      S_IDLE: begin
        ram_req.wdata = {attr, cmd.char_code};
        ram_req.we    = cmd_fire && (cmd.op == tcw_pkg::OP_PUT) && printable;
        ram_req.re    = cmd_fire && is_read && in_range;
      end
      S_TAB, S_SCROLL: begin
        ram_req.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_valid      = (state == S_DONE);
  assign res.cursor_col = 7'(cur_col);
  assign res.cursor_row = 5'(cur_row);
  assign res.cell_char  = cell_char;
  assign res.cell_attr  = cell_attr;
  assign res.scrolled   = scrolled;
  assign res.rejected   = rejected;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      k         <= '0;
      tab_last  <= '0;
      tab_next  <= '0;
      tab_wrap  <= 1'b0;
      scrolled  <= 1'b0;
      rejected  <= 1'b0;
      cell_char <= '0;
      cell_attr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == tcw_pkg::ADDR_W'(tcw_pkg::NUM_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_fire) begin
            scrolled  <= 1'b0;
            rejected  <= 1'b0;
            cell_char <= '0;
            cell_attr <= '0;
            state     <= S_DONE;
            unique case (cmd.op)
              tcw_pkg::OP_PUT: begin
                priority if (cmd.char_code == tcw_pkg::CH_NEWLINE) begin
                  cur_col <= '0;
                  if (last_row) begin
                    scrolled <= 1'b1;
                    k        <= '0;
                    state    <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else if (cmd.char_code == tcw_pkg::CH_RETURN) begin
                  cur_col <= '0;
                end else if (cmd.char_code == tcw_pkg::CH_TAB) begin
                  k        <= cur_col;
                  tab_wrap <= tab_wrap_c;
                  tab_last <= tab_wrap_c ? tcw_pkg::COL_W'(tcw_pkg::NUM_COLUMNS - 1)
                                         : tab_mask_col;
                  tab_next <= tab_mask_col + 1'b1;
                  state    <= S_TAB;
                end else begin
                  if (last_col) begin
                    cur_col <= '0;
                    if (last_row) begin
                      scrolled <= 1'b1;
                      k        <= '0;
                      state    <= S_SCROLL;
                    end else begin
                      cur_row <= cur_row + 1'b1;
                    end
                  end else begin
                    cur_col <= cur_col + 1'b1;
                  end
                end
              end
              tcw_pkg::OP_MOVE: begin
                if (in_range) begin
                  cur_row <= tcw_pkg::ROW_W'(cmd.row);
                  cur_col <= tcw_pkg::COL_W'(cmd.col);
                end else begin
                  rejected <= 1'b1;
                end
              end
              tcw_pkg::OP_READ: begin
                if (in_range) begin
                  state <= S_READ;
                end else begin
                  rejected <= 1'b1;
                end
              end
              tcw_pkg::OP_NOP: begin
              end
            endcase
          end
        end
        S_TAB: begin
          k <= k + 1'b1;
          if (k == tab_last) begin
            state <= S_DONE;
            if (tab_wrap) begin
              cur_col <= '0;
              if (last_row) begin
                scrolled <= 1'b1;
                k        <= '0;
                state    <= S_SCROLL;
              end else begin
                cur_row <= cur_row + 1'b1;
              end
            end else begin
              cur_col <= tab_next;
            end
          end
        end
        S_SCROLL: begin
          k <= k + 1'b1;
          if (k == tcw_pkg::COL_W'(tcw_pkg::NUM_COLUMNS - 1)) begin
            top   <= (top == tcw_pkg::ROW_W'(tcw_pkg::NUM_ROWS - 1)) ? '0 : top + 1'b1;
            state <= S_DONE;
          end
        end
        S_READ: begin
          cell_char <= ram_rdata[7:0];
          cell_attr <= ram_rdata[15:8];
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCW_ASSERT_NOW(a_row_range, 1'b1, 32'(cur_row) < tcw_pkg::NUM_ROWS, "cursor row out of range")
  `TCW_ASSERT_NOW(a_col_range, 1'b1, 32'(cur_col) < tcw_pkg::NUM_COLUMNS, "cursor col out of range")
  `TCW_ASSERT_NOW(a_tab_bound, state == S_TAB, k <= tab_last, "tab blanking past its end")
  `TCW_ASSERT_NEXT(a_scroll_top, (state == S_SCROLL) && (k == tcw_pkg::COL_W'(tcw_pkg::NUM_COLUMNS - 1)), top != $past(top), "scroll did not advance top row")
  `TCW_ASSERT_NEXT(a_busy_after_accept, cmd_fire, !cmd.ready, "command taken while busy")

endmodule

/* rtl/text_console_writer.sv */
// Flow: the one-port cell RAM sequencer takes a command only when idle; a read then
// passes S_READ, a tab S_TAB blanking cells, a scroll S_SCROLL blanking one row,
// before S_DONE passes the result on; no new command is taken until it has gone.
// Reset: synchronous; a clearing pass writes every cell blank (NUM_CELLS = 2000 cells)
// with the command channel not ready; attribute register resets to 07.
// Depends on tcw_pkg, tcw_cmd_if, tcw_rsp_if, tcw_cell_ram and tcw_ctrl.
module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  tcw_cmd_if.sink     cmd,
  tcw_rsp_if.source   rsp
);

  logic [7:0]                    attr;
  logic                          res_valid;
  logic                          res_ready;
  tcw_pkg::res_t                 res;
  tcw_pkg::ram_req_t             ram_req;
  logic [tcw_pkg::CELL_W-1:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::RESET_ATTR;
    end else if (cfg_we) begin
      attr <= cfg_wdata;
    end
  end

  tcw_cell_ram #(
    .DEPTH (tcw_pkg::NUM_CELLS),
    .WIDTH (tcw_pkg::CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // hold the result until the response transaction completes
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp.cursor_col <= res.cursor_col;
      rsp.cursor_row <= res.cursor_row;
      rsp.cell_char  <= res.cell_char;
      rsp.cell_attr  <= res.cell_attr;
      rsp.scrolled   <= res.scrolled;
      rsp.rejected   <= res.rejected;
    end
  end

endmodule
